FILE: rtl/cdt_pkg.sv
package cdt_pkg;

  localparam int OP_W       = 2;
  localparam int SEC_W      = 7;
  localparam int TICK_W     = 3;
  localparam int TEMP_W     = 10;
  localparam int ADC_W      = 10;
  localparam int RUN_W      = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 10;

  // tenths = floor(adc * TENTHS_FULL / ADC_FULL_SCALE)
  localparam int TENTHS_FULL    = 1000;
  localparam int ADC_FULL_SCALE = 1023;
  localparam int PROD_W         = ADC_W + TEMP_W;

  typedef enum logic [OP_W-1:0] {
    OP_MODE_BUTTON  = 2'd0,
    OP_START_BUTTON = 2'd1,
    OP_LONG_TICK    = 2'd2,
    OP_SHORT_TICK   = 2'd3
  } op_t;

  typedef enum logic [RUN_W-1:0] {
    RUN_IDLE  = 2'd0,
    RUN_LONG  = 2'd1,
    RUN_SHORT = 2'd2
  } run_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_LONG_SECONDS    = 3'd0,
    CFG_SHORT_SECONDS   = 3'd1,
    CFG_LONG_TICKS      = 3'd2,
    CFG_SHORT_TICKS     = 3'd3,
    CFG_ALARM_THRESHOLD = 3'd4
  } cfg_addr_t;

  localparam logic MODE_LONG  = 1'b0;
  localparam logic MODE_SHORT = 1'b1;

  localparam logic [SEC_W-1:0]  LONG_SECONDS_RST    = 7'd60;
  localparam logic [SEC_W-1:0]  SHORT_SECONDS_RST   = 7'd10;
  localparam logic [TICK_W-1:0] LONG_TICKS_RST      = 3'd5;
  localparam logic [TICK_W-1:0] SHORT_TICKS_RST     = 3'd4;
  localparam logic [TEMP_W-1:0] ALARM_THRESHOLD_RST = 10'd500;

  typedef struct packed {
    op_t               op;
    logic              confirmed;
    logic [TEMP_W-1:0] tenths;
  } cmd_t;

  typedef struct packed {
    run_t              run_state;
    logic              mode;
    logic [SEC_W-1:0]  remaining_seconds;
    logic [TEMP_W-1:0] temperature_tenths;
    logic              alarm_led;
    logic              started;
    logic              second_elapsed;
    logic              finished;
    logic              selection_changed;
  } result_t;

endpackage

FILE: rtl/cdt_if.sv
interface cdt_req_if;
  logic                       valid;
  logic                       ready;
  logic [cdt_pkg::OP_W-1:0]   operation;
  logic                       button_confirmed;
  logic [cdt_pkg::ADC_W-1:0]  adc_sample;

  modport source (output valid, output operation, output button_confirmed,
                  output adc_sample, input ready);
  modport sink   (input valid, input operation, input button_confirmed,
                  input adc_sample, output ready);
endinterface

interface cdt_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [cdt_pkg::RUN_W-1:0]  run_state;
  logic                       mode;
  logic [cdt_pkg::SEC_W-1:0]  remaining_seconds;
  logic [cdt_pkg::TEMP_W-1:0] temperature_tenths;
  logic                       alarm_led;
  logic                       started;
  logic                       second_elapsed;
  logic                       finished;
  logic                       selection_changed;

  modport source (output valid, output run_state, output mode, output remaining_seconds,
                  output temperature_tenths, output alarm_led, output started,
                  output second_elapsed, output finished, output selection_changed,
                  input ready);
  modport sink   (input valid, input run_state, input mode, input remaining_seconds,
                  input temperature_tenths, input alarm_led, input started,
                  input second_elapsed, input finished, input selection_changed,
                  output ready);
endinterface

interface cdt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cdt_pkg::CFG_ADDR_W-1:0] addr;
  logic [cdt_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

FILE: rtl/cdt_front.sv
module cdt_front (
  input  logic [cdt_pkg::OP_W-1:0]  operation,
  input  logic                      button_confirmed,
  input  logic [cdt_pkg::ADC_W-1:0] adc_sample,
  output cdt_pkg::cmd_t             cmd
);

  logic [cdt_pkg::PROD_W-1:0] prod;
  logic [cdt_pkg::TEMP_W-1:0] quo;
  logic [cdt_pkg::ADC_W:0]    rem;
  logic [cdt_pkg::TEMP_W-1:0] tenths;

  // Divide by 1023 as divide by 1024 plus one correction: the remainder
  // p - q*1023 = (p mod 1024) + q stays below twice the divisor.
  always_comb begin
    prod = cdt_pkg::PROD_W'(adc_sample) * cdt_pkg::PROD_W'(cdt_pkg::TENTHS_FULL);
    quo  = prod[cdt_pkg::PROD_W-1 -: cdt_pkg::TEMP_W];
    rem  = {1'b0, prod[cdt_pkg::ADC_W-1:0]} + (cdt_pkg::ADC_W+1)'(quo);
    if (rem >= (cdt_pkg::ADC_W+1)'(cdt_pkg::ADC_FULL_SCALE)) begin
      tenths = quo + cdt_pkg::TEMP_W'(1);
    end else begin
      tenths = quo;
    end
  end

  assign cmd.op        = cdt_pkg::op_t'(operation);
  assign cmd.confirmed = button_confirmed;
  assign cmd.tenths    = tenths;

endmodule

FILE: rtl/cdt_queue.sv
module cdt_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  cdt_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output cdt_pkg::cmd_t pop_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cdt_pkg::cmd_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

FILE: rtl/cdt_back.sv
module cdt_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  cdt_pkg::cmd_t                  cmd,
  input  logic                           cfg_valid,
  input  logic [cdt_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [cdt_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           res_valid,
  input  logic                           res_ready,
  output cdt_pkg::result_t               res
);

  logic [cdt_pkg::SEC_W-1:0]  long_seconds;
  logic [cdt_pkg::SEC_W-1:0]  short_seconds;
  logic [cdt_pkg::TICK_W-1:0] long_ticks;
  logic [cdt_pkg::TICK_W-1:0] short_ticks;
  logic [cdt_pkg::TEMP_W-1:0] alarm_threshold;

  cdt_pkg::run_t              run_state;
  logic                       mode;
  logic [cdt_pkg::SEC_W-1:0]  seconds_left;
  logic [cdt_pkg::TICK_W-1:0] subtick;
  logic [cdt_pkg::TEMP_W-1:0] temperature;
  logic                       led;

  cdt_pkg::run_t              run_state_next;
  logic                       mode_next;
  logic [cdt_pkg::SEC_W-1:0]  seconds_left_next;
  logic [cdt_pkg::TICK_W-1:0] subtick_next;
  logic [cdt_pkg::TEMP_W-1:0] temperature_next;
  logic                       led_next;
  logic                       started;
  logic                       elapsed;
  logic                       finished;
  logic                       changed;

  logic                       hot;
  logic                       idle_press;
  cdt_pkg::run_t              tick_owner;
  logic [cdt_pkg::TICK_W-1:0] tick_limit;
  logic [cdt_pkg::TICK_W-1:0] subtick_inc;
  logic                       second_done;

  assign cmd_ready = !res_valid || res_ready;

  always_comb begin
    hot         = (cmd.tenths > alarm_threshold);
    idle_press  = cmd.confirmed && (run_state == cdt_pkg::RUN_IDLE);
    tick_owner  = (cmd.op == cdt_pkg::OP_LONG_TICK) ? cdt_pkg::RUN_LONG : cdt_pkg::RUN_SHORT;
    tick_limit  = (cmd.op == cdt_pkg::OP_LONG_TICK) ? long_ticks : short_ticks;
    subtick_inc = subtick + cdt_pkg::TICK_W'(1);
    // a wrapped count also closes the second, and a limit of zero fires every tick
    second_done = (subtick_inc >= tick_limit) || (subtick_inc == '0);

    run_state_next    = run_state;
    mode_next         = mode;
    seconds_left_next = seconds_left;
    subtick_next      = subtick;
    temperature_next  = temperature;
    led_next          = led;
    started           = 1'b0;
    elapsed           = 1'b0;
    finished          = 1'b0;
    changed           = 1'b0;

    case (cmd.op)
      cdt_pkg::OP_MODE_BUTTON: begin
        if (idle_press) begin
          mode_next = ~mode;
          changed   = 1'b1;
        end
      end
      cdt_pkg::OP_START_BUTTON: begin
        if (idle_press) begin
          if (mode == cdt_pkg::MODE_SHORT) begin
            run_state_next    = cdt_pkg::RUN_SHORT;
            seconds_left_next = short_seconds;
          end else begin
            run_state_next    = cdt_pkg::RUN_LONG;
            seconds_left_next = long_seconds;
          end
          subtick_next     = '0;
          temperature_next = cmd.tenths;
          led_next         = hot;
          started          = 1'b1;
        end
      end
      cdt_pkg::OP_LONG_TICK, cdt_pkg::OP_SHORT_TICK: begin
        if (run_state == tick_owner) begin
          if (second_done) begin
            subtick_next = '0;
            if (seconds_left != '0) begin
              seconds_left_next = seconds_left - cdt_pkg::SEC_W'(1);
              temperature_next  = cmd.tenths;
              led_next          = hot;
              elapsed           = 1'b1;
            end
            if (seconds_left_next == '0) begin
              run_state_next = cdt_pkg::RUN_IDLE;
              led_next       = 1'b0;
              finished       = 1'b1;
            end
          end else begin
            subtick_next = subtick_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      long_seconds    <= cdt_pkg::LONG_SECONDS_RST;
      short_seconds   <= cdt_pkg::SHORT_SECONDS_RST;
      long_ticks      <= cdt_pkg::LONG_TICKS_RST;
      short_ticks     <= cdt_pkg::SHORT_TICKS_RST;
      alarm_threshold <= cdt_pkg::ALARM_THRESHOLD_RST;
      run_state       <= cdt_pkg::RUN_IDLE;
      mode            <= cdt_pkg::MODE_LONG;
      seconds_left    <= '0;
      subtick         <= '0;
      temperature     <= '0;
      led             <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cdt_pkg::cfg_addr_t'(cfg_addr))
          cdt_pkg::CFG_LONG_SECONDS:    long_seconds    <= cfg_data[cdt_pkg::SEC_W-1:0];
          cdt_pkg::CFG_SHORT_SECONDS:   short_seconds   <= cfg_data[cdt_pkg::SEC_W-1:0];
          cdt_pkg::CFG_LONG_TICKS:      long_ticks      <= cfg_data[cdt_pkg::TICK_W-1:0];
          cdt_pkg::CFG_SHORT_TICKS:     short_ticks     <= cfg_data[cdt_pkg::TICK_W-1:0];
          cdt_pkg::CFG_ALARM_THRESHOLD: alarm_threshold <= cfg_data[cdt_pkg::TEMP_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_valid && cmd_ready) begin
        run_state    <= run_state_next;
        mode         <= mode_next;
        seconds_left <= seconds_left_next;
        subtick      <= subtick_next;
        temperature  <= temperature_next;
        led          <= led_next;
        res_valid    <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      res.run_state          <= run_state_next;
      res.mode               <= mode_next;
      res.remaining_seconds  <= seconds_left_next;
      res.temperature_tenths <= temperature_next;
      res.alarm_led          <= led_next;
      res.started            <= started;
      res.second_elapsed     <= elapsed;
      res.finished           <= finished;
      res.selection_changed  <= changed;
    end
  end

endmodule

FILE: rtl/dual_mode_countdown_thermometer.sv
// A request passes through a queue slot, then the result register, before its result
// can be taken.
// Throughput: one request per cycle while the result is not stalled; a QUEUE_DEPTH-entry
// queue between the decode front and the update back absorbs output stalls.
// Reset: synchronous rst empties the queue and result register, goes idle in long
// mode with all counts zero, and restores the register defaults.
module dual_mode_countdown_thermometer #(
  parameter int QUEUE_DEPTH = 2
) (
  input logic       clk,
  input logic       rst,
  cdt_req_if.sink   req,
  cdt_rsp_if.source rsp,
  cdt_cfg_if.sink   cfg
);

  cdt_pkg::cmd_t    front_cmd;
  cdt_pkg::cmd_t    head_cmd;
  logic             head_valid;
  logic             head_ready;
  cdt_pkg::result_t res;

  cdt_front u_front (
    .operation        (req.operation),
    .button_confirmed (req.button_confirmed),
    .adc_sample       (req.adc_sample),
    .cmd              (front_cmd)
  );

  cdt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (req.valid),
    .push_ready (req.ready),
    .push_cmd   (front_cmd),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_cmd    (head_cmd)
  );

  cdt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (head_valid),
    .cmd_ready (head_ready),
    .cmd       (head_cmd),
    .cfg_valid (cfg.valid),
    .cfg_addr  (cfg.addr),
    .cfg_data  (cfg.data),
    .res_valid (rsp.valid),
    .res_ready (rsp.ready),
    .res       (res)
  );

  assign cfg.ready              = 1'b1;
  assign rsp.run_state          = res.run_state;
  assign rsp.mode               = res.mode;
  assign rsp.remaining_seconds  = res.remaining_seconds;
  assign rsp.temperature_tenths = res.temperature_tenths;
  assign rsp.alarm_led          = res.alarm_led;
  assign rsp.started            = res.started;
  assign rsp.second_elapsed     = res.second_elapsed;
  assign rsp.finished           = res.finished;
  assign rsp.selection_changed  = res.selection_changed;

endmodule

FILE: rtl/cdt_checker.sv
module cdt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [cdt_pkg::RUN_W-1:0]     run_state,
  input logic                          alarm_led,
  input logic                          started,
  input logic                          second_elapsed,
  input logic                          finished,
  input logic                          selection_changed
);

  // hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // keep the LED dark on every valid result that reports idle
  a_idle_dark: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (run_state == cdt_pkg::RUN_IDLE) |-> !alarm_led)
    else $error("alarm lit while idle");

  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && finished |-> (run_state == cdt_pkg::RUN_IDLE) && !started)
    else $error("finished result not idle");

  a_one_event: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> $onehot0({started, second_elapsed, selection_changed}))
    else $error("conflicting event flags");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && started |-> (run_state == cdt_pkg::RUN_LONG) ||
                             (run_state == cdt_pkg::RUN_SHORT))
    else $error("start did not enter counting");

endmodule

bind dual_mode_countdown_thermometer cdt_checker u_cdt_checker (
  .clk               (clk),
  .rst               (rst),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .run_state         (rsp.run_state),
  .alarm_led         (rsp.alarm_led),
  .started           (rsp.started),
  .second_elapsed    (rsp.second_elapsed),
  .finished          (rsp.finished),
  .selection_changed (rsp.selection_changed)
);
